@@ src/dsqrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dsqrt_pkg: shared constants and tables for the decimal square root
// Field widths, port packing widths and the table of powers of one hundred.
// ----------------------------------------------------------------------------
package dsqrt_pkg;

   localparam int unsigned RAD_W              = 31;
   localparam int unsigned PLACES_W           = 3;
   localparam int unsigned ROOT_W             = 36;
   localparam int unsigned REQ_DATA_W         = 40;
   localparam int unsigned RSP_DATA_W         = 40;
   localparam int unsigned DEFAULT_MAX_PLACES = 6;

   // 100 to the power p, for p up to nine
   function automatic logic [63:0] pow100(input logic [3:0] p);
      logic [63:0] v;
      unique case (p)
         4'd0: v = 64'd1;
         4'd1: v = 64'd100;
         4'd2: v = 64'd10000;
         4'd3: v = 64'd1000000;
         4'd4: v = 64'd100000000;
         4'd5: v = 64'd10000000000;
         4'd6: v = 64'd1000000000000;
         4'd7: v = 64'd100000000000000;
         4'd8: v = 64'd10000000000000000;
         4'd9: v = 64'd1000000000000000000;
         default: v = 64'd0;
      endcase
      return v;
   endfunction

   // Bits needed to hold 100 to the power p
   function automatic int unsigned scale_bits(input int unsigned p);
      logic [63:0] v;
      v = pow100(p[3:0]);
      return $clog2(v + 64'd1);
   endfunction

endpackage

@@ src/dsqrt_scale.sv @@
// ----------------------------------------------------------------------------
// dsqrt_scale: clamp the places count and form radicand * 100^places
// Two stages: split partial products, then one wide add into the square.
// ----------------------------------------------------------------------------
module dsqrt_scale #(
   parameter int unsigned MAX_PLACES = dsqrt_pkg::DEFAULT_MAX_PLACES,
   parameter int unsigned SCALE_W    = 40,
   parameter int unsigned PAD_W      = 72
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [dsqrt_pkg::RAD_W-1:0]    radicand,
   input  logic [dsqrt_pkg::PLACES_W-1:0] places,
   output logic                          out_valid,
   output logic [PAD_W-1:0]              out_square,
   output logic [dsqrt_pkg::PLACES_W-1:0] out_places
);
   import dsqrt_pkg::*;

   localparam int unsigned HALF_W = (SCALE_W + 1) / 2;
   localparam int unsigned HI_W   = SCALE_W - HALF_W;
   localparam int unsigned LO_P_W = RAD_W + HALF_W;
   localparam int unsigned HI_P_W = RAD_W + HI_W;

   logic [PLACES_W-1:0] places_clamped;
   logic [63:0]         scale_full;
   logic [SCALE_W-1:0]  scale;

   logic                valid_a_ff, valid_a_in;
   logic [LO_P_W-1:0]   prod_lo_ff, prod_lo_in;
   logic [HI_P_W-1:0]   prod_hi_ff, prod_hi_in;
   logic [PLACES_W-1:0] places_a_ff;

   logic                valid_b_ff, valid_b_in;
   logic [PAD_W-1:0]    square_ff, square_in;
   logic [PLACES_W-1:0] places_b_ff;

   // Saturate places into one to the maximum
   always_comb begin
      priority if (places == '0) begin
         places_clamped = PLACES_W'(1);
      end else if ({1'b0, places} > 4'(MAX_PLACES)) begin
         places_clamped = PLACES_W'(MAX_PLACES);
      end else begin
         places_clamped = places;
      end
   end

   // Look up the scale factor
   assign scale_full = pow100({1'b0, places_clamped});
   assign scale      = scale_full[SCALE_W-1:0];

   // Split multiply into two narrow partial products
   assign valid_a_in = in_valid;
   assign prod_lo_in = LO_P_W'(radicand) * LO_P_W'(scale[HALF_W-1:0]);
   assign prod_hi_in = HI_P_W'(radicand) * HI_P_W'(scale[SCALE_W-1:HALF_W]);

   // Recombine partial products
   assign valid_b_in = valid_a_ff;
   assign square_in  = PAD_W'(prod_lo_ff) + (PAD_W'(prod_hi_ff) << HALF_W);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_lo_ff  <= prod_lo_in;
         prod_hi_ff  <= prod_hi_in;
         places_a_ff <= places_clamped;
         square_ff   <= square_in;
         places_b_ff <= places_a_ff;
      end
   end

   assign out_valid  = valid_b_ff;
   assign out_square = square_ff;
   assign out_places = places_b_ff;

endmodule

@@ src/dsqrt_cell.sv @@
// ----------------------------------------------------------------------------
// dsqrt_cell: one root bit of the digit recurrence
// Takes the next two square bits, tries root*4+1 against the remainder,
// and hands remainder, root and the remaining bits to the next cell.
// ----------------------------------------------------------------------------
module dsqrt_cell #(
   parameter int unsigned ROOT_N = 36,
   parameter int unsigned PAD_W  = 2 * ROOT_N,
   parameter int unsigned REM_W  = ROOT_N + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [REM_W-1:0]              in_rem,
   input  logic [ROOT_N-1:0]             in_root,
   input  logic [PAD_W-1:0]              in_bits,
   input  logic [dsqrt_pkg::PLACES_W-1:0] in_places,
   output logic                          out_valid,
   output logic [REM_W-1:0]              out_rem,
   output logic [ROOT_N-1:0]             out_root,
   output logic [PAD_W-1:0]              out_bits,
   output logic [dsqrt_pkg::PLACES_W-1:0] out_places
);
   import dsqrt_pkg::*;

   localparam int unsigned TRY_W = REM_W + 2;

   logic [TRY_W-1:0]    partial;
   logic [TRY_W-1:0]    trial;
   logic [TRY_W-1:0]    diff;
   logic                take;

   logic                valid_ff, valid_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_N-1:0]   root_ff, root_in;
   logic [PAD_W-1:0]    bits_ff, bits_in;
   logic [PLACES_W-1:0] places_ff;

   // Compare shifted remainder against root*4+1
   assign partial = {in_rem, in_bits[PAD_W-1 -: 2]};
   assign trial   = TRY_W'({in_root, 2'b01});
   assign diff    = partial - trial;
   assign take    = (partial >= trial);

   // Next remainder, root and bits
   assign valid_in = in_valid;
   assign rem_in   = take ? diff[REM_W-1:0] : partial[REM_W-1:0];
   assign root_in  = {in_root[ROOT_N-2:0], take};
   assign bits_in  = in_bits << 2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff    <= rem_in;
         root_ff   <= root_in;
         bits_ff   <= bits_in;
         places_ff <= in_places;
      end
   end

   assign out_valid  = valid_ff;
   assign out_rem    = rem_ff;
   assign out_root   = root_ff;
   assign out_bits   = bits_ff;
   assign out_places = places_ff;

endmodule

@@ src/decimal_square_root.sv @@
// ----------------------------------------------------------------------------
// decimal_square_root: square root rounded to 1..MAX_PLACES decimal places
// Pipeline from accepted word to rsp_tvalid: two scaling stages, one cell per
// root bit, then the output register.
// Throughput: one word per cycle; the whole chain stalls while the output
// word waits. Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module decimal_square_root #(
   parameter int unsigned MAX_PLACES = dsqrt_pkg::DEFAULT_MAX_PLACES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [30:0] radicand, [33:31] places, [39:34] zero
   input  logic [dsqrt_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [35:0] scaled_root, [38:36] places_used, [39] zero
   output logic [dsqrt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import dsqrt_pkg::*;

   localparam int unsigned SCALE_W = scale_bits(MAX_PLACES);
   localparam int unsigned SQ_W    = RAD_W + SCALE_W;
   localparam int unsigned ROOT_N  = (SQ_W + 1) / 2;
   localparam int unsigned PAD_W   = 2 * ROOT_N;
   localparam int unsigned REM_W   = ROOT_N + 2;
   localparam int unsigned EXT_W   = (ROOT_N + 1 > ROOT_W) ? ROOT_N + 1 : ROOT_W;

   logic advance;

   logic                valid_chain  [0:ROOT_N];
   logic [REM_W-1:0]    rem_chain    [0:ROOT_N];
   logic [ROOT_N-1:0]   root_chain   [0:ROOT_N];
   logic [PAD_W-1:0]    bits_chain   [0:ROOT_N];
   logic [PLACES_W-1:0] places_chain [0:ROOT_N];

   logic                round_up;
   logic [EXT_W-1:0]    rounded;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [PLACES_W-1:0] places_ff;

   // Move the whole chain when the output word is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Clamp places and build the wide square
   dsqrt_scale #(
      .MAX_PLACES (MAX_PLACES),
      .SCALE_W    (SCALE_W),
      .PAD_W      (PAD_W)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .radicand   (req_tdata[RAD_W-1:0]),
      .places     (req_tdata[RAD_W +: PLACES_W]),
      .out_valid  (valid_chain[0]),
      .out_square (bits_chain[0]),
      .out_places (places_chain[0])
   );

   assign rem_chain[0]  = '0;
   assign root_chain[0] = '0;

   // One cell per root bit
   for (genvar k = 0; k < ROOT_N; k++) begin : g_cell
      dsqrt_cell #(
         .ROOT_N (ROOT_N),
         .PAD_W  (PAD_W),
         .REM_W  (REM_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .in_valid   (valid_chain[k]),
         .in_rem     (rem_chain[k]),
         .in_root    (root_chain[k]),
         .in_bits    (bits_chain[k]),
         .in_places  (places_chain[k]),
         .out_valid  (valid_chain[k+1]),
         .out_rem    (rem_chain[k+1]),
         .out_root   (root_chain[k+1]),
         .out_bits   (bits_chain[k+1]),
         .out_places (places_chain[k+1])
      );
   end

   // Round up when the remainder exceeds the root
   assign round_up     = (rem_chain[ROOT_N] > REM_W'(root_chain[ROOT_N]));
   assign rounded      = EXT_W'(root_chain[ROOT_N]) + EXT_W'(round_up);
   assign root_in      = rounded[ROOT_W-1:0];
   assign rsp_valid_in = valid_chain[ROOT_N];

   // Output word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         root_ff   <= root_in;
         places_ff <= places_chain[ROOT_N];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, places_ff, root_ff};

endmodule

@@ sim/root_checker.sv @@
// ----------------------------------------------------------------------------
// root_checker: result checker for the decimal square root
// Watches both stream channels. Each accepted request word is turned into the
// expected rounded root, and each accepted response word is compared with the
// oldest expectation field by field.
// ----------------------------------------------------------------------------
module root_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // [30:0] radicand, [33:31] places, [39:34] zero
   input  logic [dsqrt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [35:0] scaled_root, [38:36] places_used, [39] zero
   input  logic [dsqrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               error_count,
   output int                               pending_count,
   output int                               checked_count
);
   import dsqrt_pkg::*;

   typedef struct packed {
      logic [ROOT_W-1:0]   root;
      logic [PLACES_W-1:0] places;
   } root_word_type;

   root_word_type expected_roots[$];

   // Clamp places, scale the radicand by 100^places, take the rounded root
   function automatic root_word_type rounded_scaled_root(
      input logic [RAD_W-1:0]    radicand,
      input logic [PLACES_W-1:0] places
   );
      root_word_type       word;
      logic [PLACES_W-1:0] used;
      logic [127:0]        scale;
      logic [127:0]        scaled;
      logic [127:0]        trial;
      logic [127:0]        root;
      used = places;
      if (used < 1) used = 1;
      if (used > DEFAULT_MAX_PLACES) used = PLACES_W'(DEFAULT_MAX_PLACES);
      scale = 128'd1;
      for (int i = 0; i < used; i++) scale = scale * 128'd100;
      scaled = 128'(radicand) * scale;
      // Build the floor root one bit at a time from the top
      root = '0;
      for (int b = 39; b >= 0; b--) begin
         trial = root | (128'd1 << b);
         if (trial * trial <= scaled) root = trial;
      end
      // Round up when the true root lies above root + 1/2
      if (scaled > root * root + root) root = root + 128'd1;
      word.root   = root[ROOT_W-1:0];
      word.places = used;
      return word;
   endfunction

   // Queue expectations and compare results on each handshake
   always @(posedge clock) begin
      root_word_type want;
      root_word_type got;
      if (reset) begin
         expected_roots.delete();
         error_count   <= 0;
         pending_count <= 0;
         checked_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_roots.push_back(rounded_scaled_root(req_tdata[RAD_W-1:0],
                                                         req_tdata[RAD_W +: PLACES_W]));
         if (rsp_tvalid && rsp_tready) begin
            got.root   = rsp_tdata[ROOT_W-1:0];
            got.places = rsp_tdata[ROOT_W +: PLACES_W];
            if (expected_roots.size() == 0) begin
               error_count <= error_count + 1;
               $display("%0t: unexpected word: root %0d places %0d",
                        $time, got.root, got.places);
            end else begin
               want = expected_roots.pop_front();
               checked_count <= checked_count + 1;
               if (got.root !== want.root) begin
                  error_count <= error_count + 1;
                  $display("%0t: scaled_root expected %0d actual %0d",
                           $time, want.root, got.root);
               end else if (got.places !== want.places) begin
                  error_count <= error_count + 1;
                  $display("%0t: places_used expected %0d actual %0d",
                           $time, want.places, got.places);
               end
            end
         end
         pending_count <= expected_roots.size();
      end
   end

endmodule

@@ sim/tb_decimal_square_root.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_square_root: testbench for the decimal square root
// Sends directed corner words, then random radicands and place counts in three
// idling phases, and lets root_checker judge every response word.
// ----------------------------------------------------------------------------
module tb_decimal_square_root;
   import dsqrt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_WORDS = 625;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  req_took;
   int                    error_count;
   int                    pending_count;
   int                    checked_count;
   int                    send_idle;
   int                    recv_idle;
   int                    sent_count;
   int                    cycle_count;

   decimal_square_root u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   root_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Note request acceptance at the rising edge for the driver
   always @(posedge clock) begin
      if (reset) req_took <= 1'b0;
      else       req_took <= req_tvalid && req_tready;
   end

   // Stall the response side at random
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Drive one request word and hold it until accepted
   task automatic send_root_request(input logic [RAD_W-1:0] radicand,
                                    input logic [PLACES_W-1:0] places);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[RAD_W-1:0] = radicand;
      word[RAD_W +: PLACES_W] = places;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(negedge clock); while (!req_took);
      sent_count++;
   endtask

   // Hold the sender until every expected word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Mix full-range, small, near-max and square radicands
   function automatic logic [RAD_W-1:0] pick_radicand();
      int unsigned k;
      k = $urandom_range(0, 46340);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return RAD_W'($urandom());
         4:          return RAD_W'($urandom_range(0, 1000));
         5:          return RAD_W'(32'h7FFF_FFFF - $urandom_range(0, 1000));
         6:          return RAD_W'(k * k);
         7:          return RAD_W'(k * k + ($urandom_range(0, 1) ? 1 : -1));
         default:    return RAD_W'($urandom() >> $urandom_range(0, 30));
      endcase
   endfunction

   function automatic logic [PLACES_W-1:0] pick_places();
      if ($urandom_range(0, 9) < 8) return PLACES_W'($urandom_range(1, 6));
      return PLACES_W'($urandom_range(0, 7));
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) send_root_request(pick_radicand(), pick_places());
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      send_idle   = 34;
      recv_idle   = 84;
      sent_count  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every place count, including the clamped ones, on a small radicand
      for (int p = 0; p < 8; p++) send_root_request(RAD_W'(2), PLACES_W'(p));
      // Largest radicand at low, top and clamped place counts
      send_root_request(RAD_W'(32'h7FFF_FFFF), PLACES_W'(0));
      send_root_request(RAD_W'(32'h7FFF_FFFF), PLACES_W'(6));
      send_root_request(RAD_W'(32'h7FFF_FFFF), PLACES_W'(7));
      // Zero radicand and the smallest positive one
      send_root_request(RAD_W'(0), PLACES_W'(3));
      send_root_request(RAD_W'(0), PLACES_W'(7));
      send_root_request(RAD_W'(1), PLACES_W'(1));
      send_root_request(RAD_W'(1), PLACES_W'(6));
      // Perfect squares and a round-up case
      send_root_request(RAD_W'(4), PLACES_W'(2));
      send_root_request(RAD_W'(2147395600), PLACES_W'(6));
      send_root_request(RAD_W'(31), PLACES_W'(1));
      // Alternating bit patterns
      send_root_request(RAD_W'(32'h5555_5555), PLACES_W'(5));
      send_root_request(RAD_W'(32'h2AAA_AAAA), PLACES_W'(4));
      send_root_request(RAD_W'(32'h4000_0000), PLACES_W'(6));
      drain_results();

      // Sender idles lightly, receiver heavily
      run_random(RANDOM_WORDS);
      drain_results();

      // Swap the idling
      send_idle = 84;
      recv_idle = 34;
      run_random(RANDOM_WORDS);
      drain_results();

      // Full rate on both sides
      send_idle = 0;
      recv_idle = 0;
      run_random(RANDOM_WORDS);
      drain_results();
      repeat (80) @(negedge clock);

      $display("Sent %0d words (corners, clamped places, zero, squares), three idling phases;",
               sent_count);
      $display("checked %0d response words, %0d mismatches.", checked_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
